[rtl/kruskal_min_spanning_forest_macros.svh]
// Assertion macros for the spanning forest block checkers.
`ifndef KRUSKAL_MIN_SPANNING_FOREST_MACROS_SVH
`define KRUSKAL_MIN_SPANNING_FOREST_MACROS_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define KMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define KMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/kms_pkg.sv]
// Package: types and constants of the spanning forest block.
`default_nettype none
package kms_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 64;
  localparam int WEIGHT_BITS  = 16;
  localparam int STEP_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [20:0] COST_MAX = 21'h1FFFFF;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EDGE    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  src_vertex;
    logic [4:0]  dst_vertex;
    logic [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [4:0]  edge_src;
    logic [4:0]  edge_dst;
    logic [15:0] edge_cost;
    logic [20:0] total_cost;
    logic [5:0]  component_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]             s;
    logic [4:0]             d;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic rotate;
  } ecell_ctrl_t;

  typedef struct packed {
    logic       init;
    logic       merge;
    logic [4:0] la;
    logic [4:0] lb;
  } vcell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN_A, S_RUN_B, S_EMIT, S_COUNT, S_SUMMARY
  } state_t;
endpackage
`default_nettype wire

[rtl/kms_edge_cell.sv]
// One cell of the weight-ordered edge chain.
`default_nettype none
module kms_edge_cell import kms_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  ecell_ctrl_t ctrl,
  input  edge_t       new_edge,
  input  wire         prev_gt,
  input  edge_t       prev_edge,
  input  wire         prev_valid,
  input  edge_t       next_edge,
  input  wire         next_valid,
  output edge_t       edge_q,
  output logic        valid_q,
  output logic        gt
);
  edge_t edge_r;
  logic  valid_r;

  // Insertion point: first cell empty or heavier than the new edge.
  assign gt      = !valid_r || (edge_r.w > new_edge.w);
  assign edge_q  = edge_r;
  assign valid_q = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.insert) begin
      if (prev_gt) begin
        edge_r  <= prev_edge;
        valid_r <= prev_valid;
      end else if (gt) begin
        edge_r  <= new_edge;
        valid_r <= 1'b1;
      end
    end else if (ctrl.rotate) begin
      edge_r  <= next_edge;
      valid_r <= next_valid;
    end
  end
endmodule
`default_nettype wire

[rtl/kms_vtx_cell.sv]
// One vertex cell: holds the set label of its vertex.
`default_nettype none
module kms_vtx_cell import kms_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [4:0]  vtx_id,
  input  vcell_ctrl_t ctrl,
  output logic [4:0]  label,
  output logic        is_root
);
  logic [4:0] label_r;

  assign label   = label_r;
  assign is_root = (label_r == vtx_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= vtx_id;
    end else if (ctrl.init) begin
      label_r <= vtx_id;
    end else if (ctrl.merge && label_r == ctrl.lb) begin
      label_r <= ctrl.la;
    end
  end
endmodule
`default_nettype wire

[rtl/kruskal_min_spanning_forest.sv]
// Top level: minimum spanning forest engine over a stored edge list.
`default_nettype none
// Edges are kept weight-ordered at all times in a chain of edge cells: an add
// inserts behind every edge of equal weight, so load order breaks ties. A
// run rotates the whole chain once (MAX_EDGES steps). An empty or stale slot
// is rotated past in S_RUN_A, a stored in-range edge needs two set-label
// reads (S_RUN_A, S_RUN_B), and an accepted edge also passes S_EMIT, where
// its result is emitted. A component count over the vertex cells (S_COUNT)
// and the summary follow. Sets are tracked as labels in a row of vertex
// cells; a merge relabels every cell that holds the joined label. Add and
// clear answer with an ack the cycle after the transfer. The input stays
// blocked while any result waits, so an add or clear is taken only once the
// last result has been taken. One item is worked at a time.
module kruskal_min_spanning_forest import kms_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [5:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [5:0]  nv_r;
  logic [5:0]  n_eff;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [4:0]  lu_r, lu_nxt;
  logic [4:0]  cidx_r, cidx_nxt;
  logic [5:0]  comps_r, comps_nxt;
  logic [20:0] cost_r, cost_nxt;
  logic [21:0] cost_sum;

  ecell_ctrl_t ectl;
  vcell_ctrl_t vctl;
  edge_t       new_edge;
  edge_t       e_q [MAX_EDGES];
  logic        e_v [MAX_EDGES];
  logic        e_gt [MAX_EDGES];
  logic [4:0]  lbl [MAX_VERTICES];
  logic        root [MAX_VERTICES];
  edge_t       head;
  logic [4:0]  rd_sel, rd_label;
  logic        head_skip, add_range, store_full, in_xfer;

  assign cfg_ready = 1'b1;
  assign n_eff     = (nv_r > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : nv_r;
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign new_edge.s = in_data.src_vertex;
  assign new_edge.d = in_data.dst_vertex;
  assign new_edge.w = WEIGHT_BITS'(in_data.edge_weight);

  assign add_range  = ({1'b0, in_data.src_vertex} >= n_eff) ||
                      ({1'b0, in_data.dst_vertex} >= n_eff);
  assign store_full = e_v[MAX_EDGES-1];

  // Edge chain; cell 0 is the head seen during a run.
  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_edge
    kms_edge_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ectl),
      .new_edge   (new_edge),
      .prev_gt    ((i == 0) ? 1'b0 : e_gt[(i == 0) ? 0 : i-1]),
      .prev_edge  (e_q[(i == 0) ? 0 : i-1]),
      .prev_valid (e_v[(i == 0) ? 0 : i-1]),
      .next_edge  (e_q[(i + 1) % MAX_EDGES]),
      .next_valid (e_v[(i + 1) % MAX_EDGES]),
      .edge_q     (e_q[i]),
      .valid_q    (e_v[i]),
      .gt         (e_gt[i])
    );
  end

  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_vtx
    kms_vtx_cell u_vtx (
      .clk     (clk),
      .rst_n   (rst_n),
      .vtx_id  (5'(j)),
      .ctrl    (vctl),
      .label   (lbl[j]),
      .is_root (root[j])
    );
  end

  assign head      = e_q[0];
  assign head_skip = !e_v[0] || ({1'b0, head.s} >= n_eff) || ({1'b0, head.d} >= n_eff);
  // One label read a cycle: src in the first step, dst in the second.
  assign rd_sel    = (state_r == S_RUN_B) ? head.d : head.s;
  assign rd_label  = lbl[rd_sel];
  assign cost_sum  = {1'b0, cost_r} + 22'(head.w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nv_r        <= 6'(MAX_VERTICES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        nv_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    step_r <= step_nxt;
    lu_r   <= lu_nxt;
    cidx_r <= cidx_nxt;
    comps_r <= comps_nxt;
    cost_r <= cost_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    step_nxt      = step_r;
    lu_nxt        = lu_r;
    cidx_nxt      = cidx_r;
    comps_nxt     = comps_r;
    cost_nxt      = cost_r;
    ectl          = '0;
    vctl          = '0;
    vctl.la       = lu_r;
    vctl.lb       = rd_label;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_nxt      = '0;
          out_nxt.kind = KIND_ACK;
          out_nxt.last = 1'b1;
          case (in_data.cmd)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (add_range) begin
                out_nxt.status = ST_RANGE;
              end else if (store_full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ectl.insert = 1'b1;
              end
            end
            CMD_CLEAR: begin
              out_valid_nxt = 1'b1;
              ectl.clear    = 1'b1;
            end
            CMD_RUN: begin
              vctl.init = 1'b1;
              cost_nxt  = '0;
              step_nxt  = '0;
              state_nxt = S_RUN_A;
            end
            default: ;
          endcase
        end
      end
      S_RUN_A: begin
        if (head_skip) begin
          ectl.rotate = 1'b1;
          step_nxt    = step_r + 1'b1;
          if (step_r == STEP_W'(MAX_EDGES - 1)) begin
            cidx_nxt  = '0;
            comps_nxt = '0;
            state_nxt = S_COUNT;
          end
        end else begin
          lu_nxt    = rd_label;
          state_nxt = S_RUN_B;
        end
      end
      S_RUN_B: begin
        if (lu_r == rd_label) begin
          ectl.rotate = 1'b1;
          step_nxt    = step_r + 1'b1;
          state_nxt   = S_RUN_A;
          if (step_r == STEP_W'(MAX_EDGES - 1)) begin
            cidx_nxt  = '0;
            comps_nxt = '0;
            state_nxt = S_COUNT;
          end
        end else begin
          // Join the two sets and add the weight, saturating.
          vctl.merge = 1'b1;
          cost_nxt   = cost_sum[21] ? COST_MAX : cost_sum[20:0];
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt     = 1'b1;
          out_nxt           = '0;
          out_nxt.kind      = KIND_EDGE;
          out_nxt.edge_src  = head.s;
          out_nxt.edge_dst  = head.d;
          out_nxt.edge_cost = 16'(head.w);
          ectl.rotate       = 1'b1;
          step_nxt          = step_r + 1'b1;
          state_nxt         = S_RUN_A;
          if (step_r == STEP_W'(MAX_EDGES - 1)) begin
            cidx_nxt  = '0;
            comps_nxt = '0;
            state_nxt = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        if (root[cidx_r] && ({1'b0, cidx_r} < n_eff)) begin
          comps_nxt = comps_r + 1'b1;
        end
        cidx_nxt = cidx_r + 1'b1;
        if (cidx_r == 5'(MAX_VERTICES - 1)) begin
          state_nxt = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        if (!out_valid_r) begin
          out_valid_nxt           = 1'b1;
          out_nxt                 = '0;
          out_nxt.kind            = KIND_SUMMARY;
          out_nxt.total_cost      = cost_r;
          out_nxt.component_count = comps_r;
          out_nxt.last            = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/kms_checker.sv]
// Port-level checker for the spanning forest block, bound to the top level.
`default_nettype none
`include "kruskal_min_spanning_forest_macros.svh"
module kms_checker import kms_pkg::*; (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input in_item_t  in_data,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data
);
  logic ack_cmd;
  logic sum_seen;

  assign ack_cmd  = in_valid && in_ready &&
                    (in_data.cmd == CMD_ADD || in_data.cmd == CMD_CLEAR);
  assign sum_seen = out_valid && out_data.kind == KIND_SUMMARY;

  `KMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `KMS_ASSERT_NEXT(a_ack, ack_cmd, out_valid && out_data.kind == KIND_ACK && out_data.last)
  `KMS_ASSERT_NOW(a_edge_not_last, out_valid && out_data.kind == KIND_EDGE, !out_data.last)
  `KMS_ASSERT_NOW(a_summary, sum_seen, out_data.last && out_data.component_count <= 6'd32)
endmodule

bind kruskal_min_spanning_forest kms_checker u_kms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[sim/kruskal_min_spanning_forest_test.sv]
// Testbench: minimum spanning forest block, checked against an in-bench union-find predictor.
`timescale 1ns / 100ps
`default_nettype none
module kruskal_min_spanning_forest_test;
  import kms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RUN_DRAIN   = 2 * MAX_EDGES + 80;
  localparam logic [20:0] COST_CAP = 21'h1FFFFF;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [5:0] cfg_data = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  kruskal_min_spanning_forest u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: own copy of edge list, union-find and vertex count.
  edge_t      pend_edges[MAX_EDGES];
  int         pend_count;
  logic [4:0] uf_parent[MAX_VERTICES];
  logic [2:0] uf_rank[MAX_VERTICES];
  logic [5:0] vert_reg;

  out_item_t  exp_results[$];
  int         fail_count;
  int         mismatch_count;
  int         cycle_count;
  bit         hold_off;      // long receiver stall request

  function automatic int vert_limit();
    return (vert_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vert_reg);
  endfunction

  function automatic logic [4:0] uf_root(logic [4:0] x);
    logic [4:0] r;
    logic [4:0] nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[x] != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic out_item_t blank_result(logic [1:0] kind, logic [1:0] st,
                                             logic lst);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  // Work out the results of one accepted item and queue them.
  task automatic forest_predict(in_item_t it);
    int n;
    edge_t e;
    int j;
    logic [4:0] ru;
    logic [4:0] rv;
    logic [22:0] total;
    int comps;
    out_item_t r;
    n = vert_limit();
    case (it.cmd)
      CMD_ADD: begin
        if (it.src_vertex >= n || it.dst_vertex >= n)
          exp_results.push_back(blank_result(KIND_ACK, ST_RANGE, 1'b1));
        else if (pend_count >= MAX_EDGES)
          exp_results.push_back(blank_result(KIND_ACK, ST_FULL, 1'b1));
        else begin
          pend_edges[pend_count] = '{it.src_vertex, it.dst_vertex, it.edge_weight};
          pend_count++;
          exp_results.push_back(blank_result(KIND_ACK, ST_OK, 1'b1));
        end
      end
      CMD_CLEAR: begin
        pend_count = 0;
        exp_results.push_back(blank_result(KIND_ACK, ST_OK, 1'b1));
      end
      CMD_RUN: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          uf_parent[i] = 5'(i);
          uf_rank[i] = '0;
        end
        // stable insertion sort by weight
        for (int i = 1; i < pend_count; i++) begin
          e = pend_edges[i];
          j = i;
          while (j > 0 && pend_edges[j-1].w > e.w) begin
            pend_edges[j] = pend_edges[j-1];
            j--;
          end
          pend_edges[j] = e;
        end
        total = '0;
        for (int i = 0; i < pend_count; i++) begin
          e = pend_edges[i];
          if (e.s >= n || e.d >= n) continue;
          ru = uf_root(e.s);
          rv = uf_root(e.d);
          if (ru == rv) continue;
          if (uf_rank[ru] > uf_rank[rv]) uf_parent[rv] = ru;
          else if (uf_rank[ru] < uf_rank[rv]) uf_parent[ru] = rv;
          else begin
            uf_parent[rv] = ru;
            uf_rank[ru] = uf_rank[ru] + 3'd1;
          end
          total = total + e.w;
          if (total > COST_CAP) total = COST_CAP;
          r = blank_result(KIND_EDGE, ST_OK, 1'b0);
          r.edge_src = e.s;
          r.edge_dst = e.d;
          r.edge_cost = e.w;
          exp_results.push_back(r);
        end
        comps = 0;
        for (int i = 0; i < n; i++)
          if (uf_root(5'(i)) == 5'(i)) comps++;
        r = blank_result(KIND_SUMMARY, ST_OK, 1'b1);
        r.total_cost = total[20:0];
        r.component_count = 6'(comps);
        exp_results.push_back(r);
      end
      default: ;  // spare command: no result
    endcase
  endtask

  // Directed table: item plus, where obvious, the expected first result.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } step_row_t;

  step_row_t dir_rows[$];

  function automatic in_item_t mk(logic [1:0] c, int s, int d, int w);
    in_item_t it;
    it.cmd = c;
    it.src_vertex = 5'(s);
    it.dst_vertex = 5'(d);
    it.edge_weight = 16'(w);
    return it;
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    step_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Send one item with a random idle gap before it; valid stays up after the
  // transfer unless the next call idles or the bench drains.
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forest_predict(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (RUN_DRAIN) @(posedge clk);
  endtask

  task automatic write_vertices(logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vert_reg = v;
  endtask

  function automatic in_item_t rand_add(int n);
    int top;
    top = (n > 0) ? n - 1 : 0;
    // mostly in range, sometimes any vertex
    if ($urandom_range(0, 9) == 0)
      return mk(CMD_ADD, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    return mk(CMD_ADD, $urandom_range(0, top), $urandom_range(0, top),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom);
  endfunction

  // Receiver: random stalls per result, plus the long hold-off on request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_results.size() == 0) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("unexpected result %p", out_data);
          mismatch_count++;
        end else begin
          if (out_data !== exp_results[0]) begin
            fail_count++;
            if (mismatch_count < 10)
              $display("mismatch: expected %p actual %p", exp_results[0], out_data);
            mismatch_count++;
          end
          void'(exp_results.pop_front());
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("kruskal_min_spanning_forest_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    fail_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    vert_reg = 6'd32;
    pend_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty run, extremes, ties, self loop, spare command
    add_row(mk(CMD_RUN, 0, 0, 0), 1'b1, '{kind: KIND_SUMMARY, component_count: 6'd32,
            last: 1'b1, default: '0});
    add_row(mk(CMD_ADD, 0, 31, 16'hFFFF), 1'b1, blank_result(KIND_ACK, ST_OK, 1'b1));
    add_row(mk(CMD_ADD, 31, 0, 0), 1'b1, blank_result(KIND_ACK, ST_OK, 1'b1));
    add_row(mk(CMD_ADD, 5, 5, 1), 1'b1, blank_result(KIND_ACK, ST_OK, 1'b1));
    add_row(mk(CMD_ADD, 1, 2, 7), 1'b0, '0);
    add_row(mk(CMD_ADD, 2, 3, 7), 1'b0, '0);
    add_row(mk(CMD_ADD, 1, 3, 7), 1'b0, '0);
    add_row(mk(CMD_ADD, 3, 4, 16'hFFFF), 1'b0, '0);
    add_row(mk(CMD_SPARE, 31, 31, 16'hFFFF), 1'b0, '0);
    add_row(mk(CMD_RUN, 0, 0, 0), 1'b0, '0);
    add_row(mk(CMD_CLEAR, 31, 31, 16'hFFFF), 1'b1, blank_result(KIND_ACK, ST_OK, 1'b1));
    add_row(mk(CMD_RUN, 0, 0, 0), 1'b0, '0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed && exp_results.size() == 0) begin
        send_item(dir_rows[i].item);
        if (exp_results.size() != 0 && exp_results[0] !== dir_rows[i].want) begin
          fail_count++;
          $display("predictor disagrees with table row %0d", i);
        end
      end else
        send_item(dir_rows[i].item);
      wait_drained();
    end

    // range errors with a small vertex count, then stale edges after lowering
    write_vertices(6'd4);
    send_item(mk(CMD_ADD, 4, 0, 3));
    send_item(mk(CMD_ADD, 0, 4, 3));
    send_item(mk(CMD_ADD, 0, 3, 2));
    wait_drained();
    write_vertices(6'd32);
    for (int i = 0; i < 6; i++) send_item(mk(CMD_ADD, 20 + i, 21 + i, 16'hFFFF));
    send_item(mk(CMD_ADD, 0, 1, 9));
    wait_drained();
    write_vertices(6'd2);
    send_item(mk(CMD_RUN, 0, 0, 0));
    wait_drained();
    write_vertices(6'd0);
    send_item(mk(CMD_ADD, 0, 0, 1));
    send_item(mk(CMD_RUN, 0, 0, 0));
    wait_drained();
    write_vertices(6'd63);   // above range acts as the maximum

    // fill the store past capacity with near-maximum weights, long output stall
    send_item(mk(CMD_CLEAR, 0, 0, 0));
    hold_off = 1'b1;
    for (int i = 0; i < MAX_EDGES + 3; i++)
      send_item(mk(CMD_ADD, i % 32, (i * 7 + 1) % 32, 16'hFFFF - i));
    send_item(mk(CMD_RUN, 0, 0, 0));
    wait_drained();

    // random phases with different vertex counts
    for (int ph = 0; ph < 8; ph++) begin
      write_vertices(ph == 0 ? 6'd1 : 6'($urandom_range(1, 40)));
      n = vert_limit();
      send_item(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
      for (int k = 0; k < 33; k++) begin
        case ($urandom_range(0, 19))
          0:       send_item(mk(CMD_RUN, $urandom, $urandom, $urandom));
          1:       send_item(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
          2:       send_item(mk(CMD_SPARE, $urandom, $urandom, $urandom));
          default: send_item(rand_add(n));
        endcase
      end
      send_item(mk(CMD_RUN, 0, 0, 0));
      wait_drained();
    end

    if (fail_count == 0)
      $display("kruskal_min_spanning_forest_test: PASS");
    else
      $display("kruskal_min_spanning_forest_test: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/kms_pkg.sv
rtl/kms_edge_cell.sv
rtl/kms_vtx_cell.sv
rtl/kruskal_min_spanning_forest.sv
rtl/kms_checker.sv
sim/kruskal_min_spanning_forest_test.sv
